// File: design/assert_macros.svh
// Assertion macros used by the checker of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KNC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/knc_pkg.sv
// Shared types and constants of the k-means nearest centroid assignment core.
// Depends on nothing; used by the controller, datapath, top level and checker.
package knc_pkg;

	// Fixed field widths of the input beat, result beat and cluster count data.
	localparam int COORD_W = 16;
	localparam int SLOT_W  = 4;
	localparam int ID_W    = 4;
	localparam int NCLUS_W = 5;

	// Command codes of an input beat.
	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_ASSIGN = 1'b1
	} cmd_t;

	// One input beat.
	typedef struct packed {
		cmd_t                       cmd;
		logic [SLOT_W-1:0]          slot;
		logic signed [COORD_W-1:0]  x_coord;
		logic signed [COORD_W-1:0]  y_coord;
		logic [ID_W-1:0]            prev_cluster;
		logic                       last_point;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic [ID_W-1:0] cluster_id;
		logic            changed;
		logic            pass_end;
		logic            converged;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_point;
		logic table_wr;
		logic rd_en;
		logic rd_first;
		logic rd_last;
		logic load_result;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: design/knc_datapath.sv
// Datapath of the assignment core: centroid memory, distance pipeline,
// running minimum, pass tracking and result register. Depends on knc_pkg.
module knc_datapath #(
	parameter int MAX_CLUSTERS = 16,
	localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  knc_pkg::in_item_t   in_data,
	input  knc_pkg::dp_cmd_t    cmd,
	input  logic [IDX_W-1:0]    rd_idx,
	output knc_pkg::dp_stat_t   stat,
	output logic                out_valid,
	input  logic                out_ready,
	output knc_pkg::out_item_t  out_data
);

	localparam int CW     = knc_pkg::COORD_W;
	localparam int DIFF_W = CW + 1;
	localparam int SQ_W   = 2 * CW;
	localparam int SUM_W  = SQ_W + 1;
	localparam int CMP_W  = (IDX_W > knc_pkg::ID_W) ? IDX_W : knc_pkg::ID_W;

	// Centroid memory and latched point.
	logic [2*CW-1:0]          ctab_q [MAX_CLUSTERS];
	logic signed [CW-1:0]     pt_x_q, pt_y_q;
	logic [knc_pkg::ID_W-1:0] prev_q;
	logic                     last_q;

	// Pipeline stages.
	logic                     vld_s1, vld_s2, vld_s3;
	logic                     first_s1, first_s2, first_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic [2*CW-1:0]          cen_s1;
	logic [CW-1:0]            adx_s2, ady_s2;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3;

	// Search and result state.
	logic [SUM_W-1:0]         best_dist_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     done_q;
	logic                     pass_stable_q;
	logic                     out_valid_q;
	knc_pkg::out_item_t       out_q;

	logic signed [CW-1:0]     cen_x, cen_y;
	logic signed [DIFF_W-1:0] dx, dy, adx_full, ady_full;
	logic [SUM_W-1:0]         sq_sum;
	logic                     changed;

	// The centroid memory is written by load beats and read one entry a cycle.
	always_ff @(posedge clk) begin
		if (cmd.table_wr) begin
			ctab_q[IDX_W'(in_data.slot)] <= {in_data.x_coord, in_data.y_coord};
		end
		if (cmd.rd_en) begin
			cen_s1 <= ctab_q[rd_idx];
			idx_s1 <= rd_idx;
			first_s1 <= cmd.rd_first;
			last_s1 <= cmd.rd_last;
		end
	end

	// The point of an assign beat is held for the whole search.
	always_ff @(posedge clk) begin
		if (cmd.load_point) begin
			pt_x_q <= in_data.x_coord;
			pt_y_q <= in_data.y_coord;
			prev_q <= in_data.prev_cluster;
			last_q <= in_data.last_point;
		end
	end

	// Absolute coordinate differences; they always fit in CW unsigned bits.
	assign cen_x = cen_s1[2*CW-1:CW];
	assign cen_y = cen_s1[CW-1:0];
	assign dx = DIFF_W'(pt_x_q) - DIFF_W'(cen_x);
	assign dy = DIFF_W'(pt_y_q) - DIFF_W'(cen_y);
	assign adx_full = dx[DIFF_W-1] ? -dx : dx;
	assign ady_full = dy[DIFF_W-1] ? -dy : dy;

	always_ff @(posedge clk) begin
		adx_s2 <= adx_full[CW-1:0];
		ady_s2 <= ady_full[CW-1:0];
		idx_s2 <= idx_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
	end

	// Squares, each registered on its own.
	always_ff @(posedge clk) begin
		sqx_s3 <= adx_s2 * adx_s2;
		sqy_s3 <= ady_s2 * ady_s2;
		idx_s3 <= idx_s2;
		first_s3 <= first_s2;
		last_s3 <= last_s2;
	end

	// Squared distance; the carry bit keeps the sum exact.
	assign sq_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// Running minimum. Only a strictly smaller distance replaces the best,
	// so the lower index wins a tie.
	always_ff @(posedge clk) begin
		if (vld_s3 && (first_s3 || (sq_sum < best_dist_q))) begin
			best_dist_q <= sq_sum;
			best_idx_q <= idx_s3;
		end
	end

	// Stage valid bits and the end-of-search flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3 && last_s3;
		end
	end

	assign changed = CMP_W'(best_idx_q) != CMP_W'(prev_q);

	// Result register and pass tracking. A new result is loaded only when the
	// register is empty or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pass_stable_q <= 1'b1;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
				pass_stable_q <= last_q ? 1'b1 : (pass_stable_q && !changed);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_q.cluster_id <= knc_pkg::ID_W'(best_idx_q);
			out_q.changed <= changed;
			out_q.pass_end <= last_q;
			out_q.converged <= last_q && pass_stable_q && !changed;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign stat.search_done = done_q;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// File: design/knc_controller.sv
// Controller of the assignment core: accepts beats, holds the cluster count
// register and sequences the centroid scan. Depends on knc_pkg.
module knc_controller #(
	parameter int MAX_CLUSTERS = 16,
	localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [knc_pkg::NCLUS_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  knc_pkg::in_item_t           in_data,
	output knc_pkg::dp_cmd_t            cmd,
	output logic [IDX_W-1:0]            rd_idx,
	input  knc_pkg::dp_stat_t           stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                        state_q, state_d;
	logic [knc_pkg::NCLUS_W-1:0]   nclus_q;
	logic [IDX_W-1:0]              rd_idx_q;
	logic [IDX_W-1:0]              last_idx;
	logic                          accept;
	logic                          slot_ok;

	// The cluster count register can always take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nclus_q <= knc_pkg::NCLUS_W'(1);
		end else if (cfg_valid) begin
			nclus_q <= cfg_data;
		end
	end

	// Index of the last active centroid; a count of zero acts as one and a
	// count above the table size saturates.
	always_comb begin
		priority if (nclus_q == '0) begin
			last_idx = '0;
		end else if (int'(nclus_q) > MAX_CLUSTERS) begin
			last_idx = IDX_W'(MAX_CLUSTERS - 1);
		end else begin
			last_idx = IDX_W'(nclus_q - knc_pkg::NCLUS_W'(1));
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_ok = int'(in_data.slot) < MAX_CLUSTERS;

	// Datapath commands.
	always_comb begin
		cmd.load_point = accept && (in_data.cmd == knc_pkg::CMD_ASSIGN);
		cmd.table_wr = accept && (in_data.cmd == knc_pkg::CMD_LOAD) && slot_ok;
		cmd.rd_en = (state_q == ST_ISSUE);
		cmd.rd_first = (rd_idx_q == '0);
		cmd.rd_last = (rd_idx_q == last_idx);
		cmd.load_result = (state_q == ST_EMIT) && !stat.out_busy;
	end

	assign rd_idx = rd_idx_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_data.cmd == knc_pkg::CMD_ASSIGN)) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (rd_idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.search_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ISSUE) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end else begin
				rd_idx_q <= '0;
			end
		end
	end

endmodule

// File: design/kmeans_nearest_centroid_assign_core.sv
// K-means assignment step for 2-D points. A load beat (cmd = load) writes one
// centroid into a 16-entry table and gives no result; a slot beyond the
// table is ignored. After an assign beat is accepted the block is not ready
// again until its result is loaded: the shared distance unit scans the
// active centroids one per cycle, then a three-stage pipeline (table read,
// differences, squares) drains and the result is loaded once the register is free.
// The nearest centroid by squared distance wins, the lower index on ties.
// The result register lets a finished result wait while the next beat is
// accepted. Write num_clusters (1..16) only while the block is idle, and load
// every active centroid before assigning points.
module kmeans_nearest_centroid_assign_core #(
	parameter int MAX_CLUSTERS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [knc_pkg::NCLUS_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  knc_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output knc_pkg::out_item_t          out_data
);

	localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	knc_pkg::dp_cmd_t  dp_cmd;
	knc_pkg::dp_stat_t dp_stat;
	logic [IDX_W-1:0]  rd_idx;

	// Sequencing and configuration.
	knc_controller #(
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd      (dp_cmd),
		.rd_idx   (rd_idx),
		.stat     (dp_stat)
	);

	// Centroid storage, distance unit and result register.
	knc_datapath #(
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (dp_cmd),
		.rd_idx   (rd_idx),
		.stat     (dp_stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// File: design/knc_checker.sv
// Port-level checker for the assignment core, bound to the top level.
// Depends on knc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module knc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input knc_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input knc_pkg::out_item_t out_data
);

	// A stalled result beat keeps its value.
	`KNC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

	// Convergence is only reported on the last point of a pass.
	`KNC_ASSERT_IMP(a_conv_end, clk, arst_n, out_valid && out_data.converged, out_data.pass_end, "converged without pass end")

	// A converged pass cannot end on a point that changed.
	`KNC_ASSERT_IMP(a_conv_stable, clk, arst_n, out_valid && out_data.converged, !out_data.changed, "converged on a changed point")

	// An accepted assign beat makes the block not ready in the next cycle.
	`KNC_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready && (in_data.cmd == knc_pkg::CMD_ASSIGN), !in_ready, "ready right after an assign beat")

endmodule

bind kmeans_nearest_centroid_assign_core knc_checker u_knc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
